>>> rtl/des_pkg.sv
// DES constants, types and permutation functions.
`default_nettype none
package des_pkg;
	localparam int RoundCount = 16;
	localparam int RoundCtrW = $clog2(RoundCount);
	localparam int KeyW = 48;
	localparam int BlockW = 64;
	localparam int HalfW = 32;
	localparam int SlotW = 4;
	localparam int OpW = 2;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_ENCRYPT = 2'd1,
		OP_DECRYPT = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_ROUND,
		ST_DONE
	} state_t;

	typedef logic [7:0] perm_entry_t;

	localparam perm_entry_t TabIp [64] = '{
		58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
		62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
		57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
		61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};

	localparam perm_entry_t TabFp [64] = '{
		40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
		38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
		36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
		34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};

	localparam perm_entry_t TabE [48] = '{
		32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
		16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};

	localparam perm_entry_t TabP [32] = '{
		16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
		2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};

	localparam logic [3:0] TabS [8][64] = '{
		'{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,
		  0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
		  4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,
		  15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
		'{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,
		  3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
		  0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,
		  13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
		'{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,
		  13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
		  13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,
		  1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
		'{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,
		  13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
		  10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,
		  3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
		'{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,
		  14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
		  4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,
		  11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
		'{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,
		  10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
		  9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,
		  4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
		'{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,
		  13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
		  1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,
		  6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
		'{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,
		  1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
		  7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,
		  2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

	function automatic logic [BlockW-1:0] perm_ip(input logic [BlockW-1:0] src);
		logic [BlockW-1:0] res;
		for (int i = 0; i < BlockW; i++) res[BlockW-1-i] = src[BlockW-int'(TabIp[i])];
		return res;
	endfunction

	function automatic logic [BlockW-1:0] perm_fp(input logic [BlockW-1:0] src);
		logic [BlockW-1:0] res;
		for (int i = 0; i < BlockW; i++) res[BlockW-1-i] = src[BlockW-int'(TabFp[i])];
		return res;
	endfunction

	function automatic logic [HalfW-1:0] feistel(input logic [HalfW-1:0] r,
			input logic [KeyW-1:0] k);
		logic [KeyW-1:0] x;
		logic [HalfW-1:0] s;
		logic [HalfW-1:0] res;
		logic [5:0] c;
		for (int i = 0; i < KeyW; i++) x[KeyW-1-i] = r[HalfW-int'(TabE[i])];
		x = x ^ k;
		for (int b = 0; b < 8; b++) begin
			c = x[KeyW-1-6*b -: 6];
			s[HalfW-1-4*b -: 4] = TabS[b][{c[5], c[0], c[4:1]}];
		end
		for (int i = 0; i < HalfW; i++) res[HalfW-1-i] = s[HalfW-int'(TabP[i])];
		return res;
	endfunction
endpackage
`default_nettype wire

>>> rtl/des_round.sv
// One Feistel round on a registered half-block pair.
`default_nettype none
module des_round (
	input  wire logic [des_pkg::HalfW-1:0] left,
	input  wire logic [des_pkg::HalfW-1:0] right,
	input  wire logic [des_pkg::KeyW-1:0]  round_key,
	output logic [des_pkg::HalfW-1:0]      next_left,
	output logic [des_pkg::HalfW-1:0]      next_right
);
	assign next_left = right;
	assign next_right = left ^ des_pkg::feistel(right, round_key);
endmodule
`default_nettype wire

>>> rtl/des_block_cipher_core.sv
// DES core: round key memory, iterative Feistel round and output register.
//  channel | dir | tdata (low bit up)                           | tuser
//  s_axis  | in  | key_slot, round_key_value, data_block, pad | operation
//  m_axis  | out | result_block                                | -
// Encrypt/decrypt: a fetch state for the registered read of the first round
// key, then one round a cycle until the result is valid.
// Loads write a key slot. Reset clears control only; keys are undefined until
// loaded. A stalled result holds; the next item is taken once it transfers.
`default_nettype none
module des_block_cipher_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [119:0] s_axis_tdata, // key_slot, round_key_value, data_block, pad
	input  wire logic [1:0]   s_axis_tuser, // operation
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [63:0]       m_axis_tdata  // result_block
);
	logic [des_pkg::KeyW-1:0] key_mem [des_pkg::RoundCount];
	logic [des_pkg::KeyW-1:0] key_rd_q;
	logic [des_pkg::RoundCtrW-1:0] rd_addr;
	logic [des_pkg::RoundCtrW-1:0] rnd_q;
	logic decrypt_q;
	logic [des_pkg::HalfW-1:0] left_q, right_q, nl, nr;
	des_pkg::state_t state_q, state_d;
	logic [des_pkg::SlotW-1:0] slot;
	logic [des_pkg::KeyW-1:0] kval;
	logic [des_pkg::BlockW-1:0] blk, ipv;
	des_pkg::op_t op;
	logic in_xfer, last_round;

	assign slot = s_axis_tdata[3:0];
	assign kval = s_axis_tdata[51:4];
	assign blk = s_axis_tdata[115:52];
	assign op = des_pkg::op_t'(s_axis_tuser);
	assign in_xfer = s_axis_tvalid && s_axis_tready;
	assign ipv = des_pkg::perm_ip(blk);
	assign last_round = (rnd_q == des_pkg::RoundCtrW'(des_pkg::RoundCount - 1));

	always_comb begin
		state_d = state_q;
		s_axis_tready = 1'b0;
		unique case (state_q)
			des_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid && (op == des_pkg::OP_ENCRYPT || op == des_pkg::OP_DECRYPT))
					state_d = des_pkg::ST_FETCH;
			end
			des_pkg::ST_FETCH: state_d = des_pkg::ST_ROUND;
			des_pkg::ST_ROUND: if (last_round) state_d = des_pkg::ST_DONE;
			des_pkg::ST_DONE: if (m_axis_tready) state_d = des_pkg::ST_IDLE;
			default: state_d = des_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= des_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	// address of the key for the round after rnd_q (or round 0 on fetch)
	always_comb begin
		logic [des_pkg::RoundCtrW-1:0] r;
		r = (state_q == des_pkg::ST_FETCH) ? '0 : rnd_q + 1'b1;
		rd_addr = decrypt_q ? ~r : r;
	end

	always_ff @(posedge clk) begin
		if (in_xfer && op == des_pkg::OP_LOAD) key_mem[slot] <= kval;
		key_rd_q <= key_mem[rd_addr];
	end

	des_round u_round (
		.left(left_q), .right(right_q), .round_key(key_rd_q),
		.next_left(nl), .next_right(nr)
	);

	always_ff @(posedge clk) begin
		if (state_q == des_pkg::ST_IDLE && in_xfer) begin
			left_q <= ipv[63:32];
			right_q <= ipv[31:0];
			decrypt_q <= (op == des_pkg::OP_DECRYPT);
		end
		if (state_q == des_pkg::ST_FETCH) rnd_q <= '0;
		if (state_q == des_pkg::ST_ROUND) begin
			left_q <= nl;
			right_q <= nr;
			rnd_q <= rnd_q + 1'b1;
		end
	end

	assign m_axis_tvalid = (state_q == des_pkg::ST_DONE);
	assign m_axis_tdata = des_pkg::perm_fp({right_q, left_q});
endmodule
`default_nettype wire

>>> rtl/des_core_checker.sv
// Port-level checks for the DES core, bound to the top level.
`default_nettype none
module des_core_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_axis_tvalid,
	input wire logic         s_axis_tready,
	input wire logic [1:0]   s_axis_tuser,
	input wire logic         m_axis_tvalid,
	input wire logic         m_axis_tready,
	input wire logic [63:0]  m_axis_tdata
);
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed under stall");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("input taken while result pending");
	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == des_pkg::OP_LOAD
		|=> s_axis_tready)
		else $error("load stalled the input");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == des_pkg::OP_ENCRYPT
		|=> !s_axis_tready && !m_axis_tvalid)
		else $error("block not busy after encrypt");
endmodule

bind des_block_cipher_core des_core_checker u_checker (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .s_axis_tuser(s_axis_tuser),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
